FILE: hdl/owtr_pkg.sv
// ----------------------------------------------------------------------------
// owtr_pkg
// Types and constants shared by the 1-wire temperature read block
// ----------------------------------------------------------------------------
package owtr_pkg;

	localparam int TIMER_W = 20;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_RST_LOW  = 4'd1,
		PH_RST_WAIT = 4'd2,
		PH_RST_REC  = 4'd3,
		PH_WR_LOW   = 4'd4,
		PH_WR_HIGH  = 4'd5,
		PH_CONV     = 4'd6,
		PH_RD_LOW   = 4'd7,
		PH_RD_HIGH  = 4'd8
	} phase_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_SKIP_ROM    = 3'd0,
		CFG_CONVERT     = 3'd1,
		CFG_READ_SCRATCH = 3'd2,
		CFG_CONV_WAIT   = 3'd3,
		CFG_RESET_LOW   = 3'd4
	} cfg_idx_t;

	// position in the command/byte sequence
	localparam logic [2:0] STEP_SKIP1    = 3'd0;
	localparam logic [2:0] STEP_CONVERT  = 3'd1;
	localparam logic [2:0] STEP_SKIP2    = 3'd2;
	localparam logic [2:0] STEP_READ_CMD = 3'd3;
	localparam logic [2:0] STEP_LSB      = 3'd4;
	localparam logic [2:0] STEP_MSB      = 3'd5;

	localparam logic [TIMER_W-1:0] PRESENCE_WAIT_US = 20'd80;
	localparam logic [TIMER_W-1:0] RESET_REC_US     = 20'd400;
	localparam logic [TIMER_W-1:0] WRITE_LONG_US    = 20'd50;
	localparam logic [TIMER_W-1:0] WRITE_SHORT_US   = 20'd1;
	localparam logic [TIMER_W-1:0] READ_LOW_US      = 20'd2;
	localparam logic [TIMER_W-1:0] READ_SLOT_US     = 20'd60;

	localparam logic [7:0]  SKIP_ROM_RST     = 8'd204;
	localparam logic [7:0]  CONVERT_RST      = 8'd68;
	localparam logic [7:0]  READ_SCRATCH_RST = 8'd190;
	localparam logic [19:0] CONV_WAIT_RST    = 20'd800000;
	localparam logic [9:0]  RESET_LOW_RST    = 10'd480;

	typedef struct packed {
		logic [7:0]  skip_rom_opcode;
		logic [7:0]  convert_opcode;
		logic [7:0]  read_scratch_opcode;
		logic [19:0] conversion_wait_us;
		logic [9:0]  reset_low_us;
	} cfg_t;

	typedef struct packed {
		logic               drive_low;
		logic               busy_res;
		logic               done_res;
		logic               presence_ok;
		logic signed [15:0] temperature;
	} res_t;

endpackage

FILE: hdl/onewire_temperature_read_top.sv
// ----------------------------------------------------------------------------
// onewire_temperature_read_top
// 1-wire bus master reading a raw temperature word, one item per bus tick
// the result of an accepted item is registered; with a stalled output it waits in the skid entry first
// throughput: one item per clock while m_tready stays high
// a stalled result lets one more item into a spare entry, then s_tready stays low
// until the first cycle after m_tready returns high
// reset clears the sequencer to idle and loads the default opcodes and timings
// ----------------------------------------------------------------------------
module onewire_temperature_read_top
	import owtr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// item in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] line_in, [7:1] zero
	input  logic        s_tuser,   // [0] cmd
	// result out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [0] drive_low, [1] busy_res, [2] presence_ok,
	                               // [18:3] temperature, [23:19] zero
	output logic        m_tlast,   // done_res
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_data
);

	cfg_t cfg;
	res_t res_in, res_out;
	logic step;

	assign cfg_ready = 1'b1;
	assign step      = s_tvalid && s_tready;

	owtr_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	owtr_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.step    (step),
		.cmd     (s_tuser),
		.line_in (s_tdata[0]),
		.res     (res_in)
	);

	owtr_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (res_in),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (res_out)
	);

	assign m_tdata = {5'd0, res_out.temperature, res_out.presence_ok,
		res_out.busy_res, res_out.drive_low};
	assign m_tlast = res_out.done_res;

endmodule

FILE: hdl/owtr_cfg.sv
// ----------------------------------------------------------------------------
// owtr_cfg
// Configuration register file: opcodes and timing values
// ----------------------------------------------------------------------------
module owtr_cfg
	import owtr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [19:0] wr_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.skip_rom_opcode     <= SKIP_ROM_RST;
			cfg_q.convert_opcode      <= CONVERT_RST;
			cfg_q.read_scratch_opcode <= READ_SCRATCH_RST;
			cfg_q.conversion_wait_us  <= CONV_WAIT_RST;
			cfg_q.reset_low_us        <= RESET_LOW_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_SKIP_ROM:     cfg_q.skip_rom_opcode     <= wr_data[7:0];
				CFG_CONVERT:      cfg_q.convert_opcode      <= wr_data[7:0];
				CFG_READ_SCRATCH: cfg_q.read_scratch_opcode <= wr_data[7:0];
				CFG_CONV_WAIT:    cfg_q.conversion_wait_us  <= wr_data;
				CFG_RESET_LOW:    cfg_q.reset_low_us        <= wr_data[9:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hdl/owtr_core.sv
// ----------------------------------------------------------------------------
// owtr_core
// Bus sequencer state and per-item next-state and result logic
// ----------------------------------------------------------------------------
module owtr_core
	import owtr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic step,
	input  logic cmd,
	input  logic line_in,
	output res_t res
);

	phase_t              phase_q, phase_d;
	logic [TIMER_W-1:0]  timer_q, timer_d, tmr;
	logic [2:0]          bit_q, bit_d, bit_nx;
	logic [7:0]          shift_q, shift_d;
	logic [2:0]          bstep_q, bstep_d;
	logic signed [15:0]  temp_q, temp_d;
	logic                pres_q, pres_d;
	logic                done;

	function automatic logic [TIMER_W-1:0] at_least_one(input logic [TIMER_W-1:0] t);
		return (t == '0) ? {{(TIMER_W-1){1'b0}}, 1'b1} : t;
	endfunction

	assign bit_nx = bit_q + 3'd1;

	// next state
	always_comb begin
		phase_d = phase_q;
		timer_d = timer_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		bstep_d = bstep_q;
		temp_d  = temp_q;
		pres_d  = pres_q;
		done    = 1'b0;
		tmr     = at_least_one(timer_q) - {{(TIMER_W-1){1'b0}}, 1'b1};

		if (phase_q == PH_IDLE) begin
			if (cmd) begin
				pres_d  = 1'b1;
				bstep_d = STEP_SKIP1;
				bit_d   = '0;
				shift_d = '0;
				phase_d = PH_RST_LOW;
				timer_d = at_least_one({10'd0, cfg.reset_low_us});
			end
		end else if (phase_q > PH_RD_HIGH) begin
			phase_d = PH_IDLE;
			timer_d = '0;
		end else if (!cmd) begin
			// read bit sampled in the first released microsecond
			if (phase_q == PH_RD_HIGH && timer_q == READ_SLOT_US) begin
				shift_d = {line_in, shift_q[7:1]};
			end
			timer_d = tmr;
			if (tmr == '0) begin
				unique case (phase_q)
					PH_RST_LOW: begin
						phase_d = PH_RST_WAIT;
						timer_d = PRESENCE_WAIT_US;
					end
					PH_RST_WAIT: begin
						if (line_in) pres_d = 1'b0;
						phase_d = PH_RST_REC;
						timer_d = RESET_REC_US;
					end
					PH_RST_REC: begin
						shift_d = cfg.skip_rom_opcode;
						bit_d   = '0;
						phase_d = PH_WR_LOW;
						timer_d = cfg.skip_rom_opcode[0] ? WRITE_SHORT_US : WRITE_LONG_US;
					end
					PH_WR_LOW: begin
						phase_d = PH_WR_HIGH;
						timer_d = shift_q[0] ? WRITE_LONG_US : WRITE_SHORT_US;
					end
					PH_WR_HIGH: begin
						bit_d = bit_nx;
						if (bit_nx != '0) begin
							shift_d = {1'b0, shift_q[7:1]};
							phase_d = PH_WR_LOW;
							timer_d = shift_q[1] ? WRITE_SHORT_US : WRITE_LONG_US;
						end else begin
							case (bstep_q)
								STEP_SKIP1: begin
									bstep_d = STEP_CONVERT;
									shift_d = cfg.convert_opcode;
									phase_d = PH_WR_LOW;
									timer_d = cfg.convert_opcode[0] ? WRITE_SHORT_US
										: WRITE_LONG_US;
								end
								STEP_CONVERT: begin
									shift_d = {1'b0, shift_q[7:1]};
									phase_d = PH_CONV;
									timer_d = at_least_one(cfg.conversion_wait_us);
								end
								STEP_SKIP2: begin
									bstep_d = STEP_READ_CMD;
									shift_d = cfg.read_scratch_opcode;
									phase_d = PH_WR_LOW;
									timer_d = cfg.read_scratch_opcode[0] ? WRITE_SHORT_US
										: WRITE_LONG_US;
								end
								default: begin
									bstep_d = STEP_LSB;
									shift_d = '0;
									phase_d = PH_RD_LOW;
									timer_d = READ_LOW_US;
								end
							endcase
						end
					end
					PH_CONV: begin
						bstep_d = STEP_SKIP2;
						phase_d = PH_RST_LOW;
						timer_d = at_least_one({10'd0, cfg.reset_low_us});
					end
					PH_RD_LOW: begin
						phase_d = PH_RD_HIGH;
						timer_d = READ_SLOT_US;
					end
					PH_RD_HIGH: begin
						bit_d = bit_nx;
						if (bit_nx != '0) begin
							phase_d = PH_RD_LOW;
							timer_d = READ_LOW_US;
						end else if (bstep_q == STEP_LSB) begin
							temp_d[7:0] = shift_d;
							bstep_d     = STEP_MSB;
							shift_d     = '0;
							phase_d     = PH_RD_LOW;
							timer_d     = READ_LOW_US;
						end else begin
							temp_d[15:8] = shift_d;
							bstep_d      = STEP_SKIP1;
							phase_d      = PH_IDLE;
							timer_d      = '0;
							done         = 1'b1;
						end
					end
					default: begin
						phase_d = PH_IDLE;
						timer_d = '0;
					end
				endcase
			end
		end
	end

	// result of this item, taken from the state it moves to
	always_comb begin
		res.drive_low   = (phase_d == PH_RST_LOW) || (phase_d == PH_WR_LOW) ||
			(phase_d == PH_RD_LOW);
		res.busy_res    = (phase_d != PH_IDLE);
		res.done_res    = done;
		res.presence_ok = pres_d;
		res.temperature = temp_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			timer_q <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			bstep_q <= STEP_SKIP1;
			temp_q  <= '0;
			pres_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			timer_q <= timer_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			bstep_q <= bstep_d;
			temp_q  <= temp_d;
			pres_q  <= pres_d;
		end
	end

`ifndef SYNTH
	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && done |=> phase_q == PH_IDLE)
		else $error("sequence done but phase not idle");

	a_idle_timer_clear: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> timer_q == '0)
		else $error("slot timer running while idle");

	a_busy_timer_live: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_IDLE |-> timer_q != '0)
		else $error("active phase with expired slot timer");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		bstep_q <= STEP_MSB)
		else $error("byte step out of range");
`endif

endmodule

FILE: hdl/owtr_obuf.sv
// ----------------------------------------------------------------------------
// owtr_obuf
// Result register with a skid entry so input and output stall independently
// ----------------------------------------------------------------------------
module owtr_obuf
	import owtr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  res_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_data
);

	logic valid_q, skid_valid_q, push, load;
	res_t data_q, skid_q;

	assign in_ready = !skid_valid_q;
	assign push     = in_valid && in_ready;
	assign load     = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load) begin
			valid_q      <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= skid_valid_q ? skid_q : in_data;
		end else if (push) begin
			skid_q <= in_data;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

`ifndef SYNTH
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> valid_q)
		else $error("skid entry held with empty result register");

	a_skid_drains_first: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && out_ready |=> valid_q && !skid_valid_q)
		else $error("skid entry not moved on drain");

	a_stall_fills_skid: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !out_ready && push |=> skid_valid_q && valid_q)
		else $error("item lost on stalled output");
`endif

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 1-wire temperature read master
// Runs one full read sequence against a scripted bus slave (presence pulses and
// a temperature word), then partial sequences under changing settings, with
// noise ticks, starts while busy and random stalls on both streams. Every
// result item is checked against the plan's status for typed rows, else against
// a cycle-free model of the sequencer kept in step with the accepted ticks.
// ----------------------------------------------------------------------------
module testbench;
	import owtr_pkg::*;

	localparam int PHASES = 6;
	localparam int CFG_IDX_TOP = 7;
	localparam int RUN_ALL = 100000;

	localparam res_t AT_RESET       = '{1'b0, 1'b0, 1'b0, 1'b0, 16'sd0};
	localparam res_t RESET_LOW_HELD = '{1'b1, 1'b1, 1'b0, 1'b1, 16'sd0};

	// run rows play a whole sequence; other rows are single items
	typedef struct packed {
		logic        run;
		logic        cmd;
		logic        line;
		logic [15:0] word;
		logic        miss1;
		logic        miss2;
		logic        typed;
		res_t        want;
	} plan_row_t;

	localparam plan_row_t PLAN [0:5] = '{
		'{1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b1, AT_RESET},
		'{1'b0, 1'b0, 1'b1, 16'h0000, 1'b0, 1'b0, 1'b1, AT_RESET},
		'{1'b0, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b0, 1'b1, RESET_LOW_HELD},
		// start while busy changes nothing
		'{1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b1, RESET_LOW_HELD},
		'{1'b0, 1'b0, 1'b1, 16'h0000, 1'b0, 1'b0, 1'b1, RESET_LOW_HELD},
		'{1'b1, 1'b0, 1'b0, 16'h8000, 1'b0, 1'b1, 1'b0, AT_RESET}
	};

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;   // [0] line_in, [7:1] zero
	logic        s_tuser = 1'b0;   // [0] cmd
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;          // [0] drive_low, [1] busy_res, [2] presence_ok,
	                               // [18:3] temperature, [23:19] zero
	logic        m_tlast;          // done_res
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = 3'd0;
	logic [19:0] cfg_data = 20'd0;

	// model of the sequencer
	cfg_t        cfg = '{SKIP_ROM_RST, CONVERT_RST, READ_SCRATCH_RST, CONV_WAIT_RST,
	                     RESET_LOW_RST};
	phase_t      ph = PH_IDLE;
	logic [19:0] tmr = '0;
	logic [2:0]  bitn = '0;
	logic [7:0]  shreg = '0;
	logic [2:0]  step = '0;
	logic [15:0] tword = '0;
	logic        pres = 1'b0;

	res_t awaited_status [$];

	int  faults = 0;
	int  items_sent = 0;
	int  reads_done = 0;
	int  cfg_writes = 0;
	bit  tx_calm = 1'b0;
	bit  rx_calm = 1'b0;

	onewire_temperature_read_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("testbench NOT OK");
		$finish;
	end

	// a zero length counts as one tick
	function automatic void arm(input phase_t p, input logic [19:0] ticks);
		ph = p;
		tmr = (ticks == 20'd0) ? 20'd1 : ticks;
	endfunction

	function automatic void arm_write_bit();
		arm(PH_WR_LOW, shreg[0] ? WRITE_SHORT_US : WRITE_LONG_US);
	endfunction

	function automatic void load_byte(input logic [7:0] op);
		shreg = op;
		bitn = 3'd0;
		arm_write_bit();
	endfunction

	function automatic void begin_read_byte();
		shreg = 8'd0;
		bitn = 3'd0;
		arm(PH_RD_LOW, READ_LOW_US);
	endfunction

	function automatic void next_command();
		case (step)
			STEP_SKIP1: begin
				step = STEP_CONVERT;
				load_byte(cfg.convert_opcode);
			end
			STEP_CONVERT: arm(PH_CONV, cfg.conversion_wait_us);
			STEP_SKIP2: begin
				step = STEP_READ_CMD;
				load_byte(cfg.read_scratch_opcode);
			end
			default: begin
				step = STEP_LSB;
				begin_read_byte();
			end
		endcase
	endfunction

	function automatic logic slot_finished(input logic line);
		logic fin;
		fin = 1'b0;
		case (ph)
			PH_RST_LOW: arm(PH_RST_WAIT, PRESENCE_WAIT_US);
			PH_RST_WAIT: begin
				if (line)
					pres = 1'b0;
				arm(PH_RST_REC, RESET_REC_US);
			end
			PH_RST_REC: load_byte(cfg.skip_rom_opcode);
			PH_WR_LOW: arm(PH_WR_HIGH, shreg[0] ? WRITE_LONG_US : WRITE_SHORT_US);
			PH_WR_HIGH: begin
				shreg = shreg >> 1;
				bitn = bitn + 3'd1;
				if (bitn == 3'd0)
					next_command();
				else
					arm_write_bit();
			end
			PH_CONV: begin
				step = STEP_SKIP2;
				arm(PH_RST_LOW, {10'd0, cfg.reset_low_us});
			end
			PH_RD_LOW: arm(PH_RD_HIGH, READ_SLOT_US);
			PH_RD_HIGH: begin
				bitn = bitn + 3'd1;
				if (bitn != 3'd0) begin
					arm(PH_RD_LOW, READ_LOW_US);
				end else if (step == STEP_LSB) begin
					tword[7:0] = shreg;
					step = STEP_MSB;
					begin_read_byte();
				end else begin
					tword[15:8] = shreg;
					step = STEP_SKIP1;
					ph = PH_IDLE;
					tmr = 20'd0;
					fin = 1'b1;
				end
			end
			default: begin
				ph = PH_IDLE;
				tmr = 20'd0;
			end
		endcase
		return fin;
	endfunction

	// advance the master by one accepted item and return its status
	function automatic res_t tick_master(input logic cmd, input logic line);
		res_t r;
		logic fin;
		fin = 1'b0;
		if (ph == PH_IDLE) begin
			if (cmd) begin
				pres = 1'b1;
				step = STEP_SKIP1;
				bitn = 3'd0;
				shreg = 8'd0;
				arm(PH_RST_LOW, {10'd0, cfg.reset_low_us});
			end
		end else if (!cmd) begin
			// read bit is taken in the first released microsecond
			if (ph == PH_RD_HIGH && tmr == READ_SLOT_US)
				shreg = {line, shreg[7:1]};
			if (tmr == 20'd0)
				tmr = 20'd1;
			tmr = tmr - 20'd1;
			if (tmr == 20'd0)
				fin = slot_finished(line);
		end
		r.drive_low = (ph == PH_RST_LOW) || (ph == PH_WR_LOW) || (ph == PH_RD_LOW);
		r.busy_res = (ph != PH_IDLE);
		r.done_res = fin;
		r.presence_ok = pres;
		r.temperature = tword;
		return r;
	endfunction

	task automatic send_item(input logic cmd, input logic line, input logic typed,
	                         input res_t want);
		int gap;
		res_t r;
		if ($urandom_range(0, 149) == 0)
			tx_calm = !tx_calm;
		gap = tx_calm ? 0 : $urandom_range(0, 11);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {7'd0, line};
		do @(posedge clk); while (!s_tready);
		r = tick_master(cmd, line);
		awaited_status.push_back(typed ? want : r);
		items_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (awaited_status.size() != 0);
		@(posedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] idx, input logic [19:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_SKIP_ROM:     cfg.skip_rom_opcode = val[7:0];
			CFG_CONVERT:      cfg.convert_opcode = val[7:0];
			CFG_READ_SCRATCH: cfg.read_scratch_opcode = val[7:0];
			CFG_CONV_WAIT:    cfg.conversion_wait_us = val;
			CFG_RESET_LOW:    cfg.reset_low_us = val[9:0];
			default: ;
		endcase
		cfg_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// temperature read with a scripted slave answering on the bus, for at most
	// budget ticks
	task automatic read_run(input logic [15:0] word, input logic miss1, input logic miss2,
	                        input logic noisy, input int budget);
		int ticks;
		int pause_at;
		logic lvl;
		logic miss;
		pause_at = $urandom_range(1, 3000);
		ticks = 0;
		if (ph == PH_IDLE)
			send_item(1'b1, 1'($urandom_range(0, 1)), 1'b0, '0);
		while (ph != PH_IDLE && ticks < budget) begin
			miss = (step == STEP_SKIP2) ? miss2 : miss1;
			case (ph)
				PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: lvl = 1'b0;
				// presence pulse covers the back part of the wait window
				PH_RST_WAIT: lvl = (tmr > 20'd60) ? 1'b1 : miss;
				// slave holds its data bit for about 15 us after release
				PH_RD_HIGH: lvl = (tmr > 20'd45) ? word[{(step == STEP_MSB), bitn}] : 1'b1;
				default: lvl = 1'b1;
			endcase
			if (noisy && $urandom_range(0, 63) == 0)
				lvl = !lvl;
			if (noisy && $urandom_range(0, 99) == 0)
				send_item(1'b1, lvl, 1'b0, '0);
			else
				send_item(1'b0, lvl, 1'b0, '0);
			ticks++;
			if (ticks == pause_at)
				drain();
		end
	endtask

	// result side
	initial begin
		int stall;
		res_t got;
		res_t want;
		wait (arst_n);
		forever begin
			if ($urandom_range(0, 149) == 0)
				rx_calm = !rx_calm;
			stall = rx_calm ? 0 : $urandom_range(0, 11);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got.drive_low = m_tdata[0];
			got.busy_res = m_tdata[1];
			got.done_res = m_tlast;
			got.presence_ok = m_tdata[2];
			got.temperature = m_tdata[18:3];
			if (got.done_res)
				reads_done++;
			if (awaited_status.size() == 0) begin
				if (faults < 10)
					$display("unexpected result at %0t: data %h last %b", $time, m_tdata, m_tlast);
				faults++;
			end else begin
				want = awaited_status.pop_front();
				if (got !== want) begin
					if (faults < 10) begin
						$display("mismatch at %0t: expected drive %b busy %b done %b presence %b temp %0d",
						         $time, want.drive_low, want.busy_res, want.done_res,
						         want.presence_ok, want.temperature);
						$display("  got drive %b busy %b done %b presence %b temp %0d",
						         got.drive_low, got.busy_res, got.done_res,
						         got.presence_ok, got.temperature);
					end
					faults++;
				end
			end
		end
	end

	// stimulus
	initial begin
		logic [7:0]  op_skip;
		logic [7:0]  op_conv;
		logic [7:0]  op_read;
		logic [19:0] wait_us;
		logic [9:0]  low_us;
		logic [2:0]  idx;
		int          idle_ticks;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default opcodes stay; zero wait runs as a single tick, short reset pulses
		cfg_write(CFG_CONV_WAIT, 20'd0);
		cfg_write(CFG_RESET_LOW, 20'd2);
		for (int i = 0; i < $size(PLAN); i++) begin
			if (PLAN[i].run)
				read_run(PLAN[i].word, PLAN[i].miss1, PLAN[i].miss2, 1'b0, RUN_ALL);
			else
				send_item(PLAN[i].cmd, PLAN[i].line, PLAN[i].typed, PLAN[i].want);
		end

		// sequences here run in slices that carry over between settings
		for (int p = 0; p < PHASES; p++) begin
			drain();
			if (p == 0) begin
				op_skip = 8'h00;
				op_conv = 8'h00;
				op_read = 8'h00;
				wait_us = 20'd1;
				low_us = 10'd0;
			end else if (p == 1) begin
				op_skip = 8'hFF;
				op_conv = 8'hFF;
				op_read = 8'hFF;
				wait_us = 20'hFFFFF;
				low_us = 10'h3FF;
			end else begin
				op_skip = 8'($urandom);
				op_conv = 8'($urandom);
				op_read = 8'($urandom);
				wait_us = 20'($urandom_range(1, 300));
				low_us = 10'($urandom_range(1, 120));
			end
			cfg_write(CFG_SKIP_ROM, {12'($urandom), op_skip});
			cfg_write(CFG_CONVERT, {12'($urandom), op_conv});
			cfg_write(CFG_READ_SCRATCH, {12'($urandom), op_read});
			cfg_write(CFG_CONV_WAIT, wait_us);
			// the full-scale wait is far too long to sit through
			if (p == 1)
				cfg_write(CFG_CONV_WAIT, 20'd2);
			cfg_write(CFG_RESET_LOW, {10'($urandom), low_us});
			if (p >= 2) begin
				idx = 3'($urandom_range(int'(CFG_RESET_LOW) + 1, CFG_IDX_TOP));
				cfg_write(idx, 20'($urandom));
			end
			idle_ticks = $urandom_range(5, 40);
			repeat (idle_ticks)
				send_item(1'b0, 1'($urandom_range(0, 1)), 1'b0, '0);
			read_run(16'($urandom), $urandom_range(0, 4) == 0, $urandom_range(0, 4) == 0,
			         1'b1, $urandom_range(60, 120));
		end

		s_tvalid <= 1'b0;
		do @(negedge clk); while (awaited_status.size() != 0);
		repeat (4) @(posedge clk);

		$display("ran %0d bus items through %0d complete temperature reads", items_sent,
		         reads_done);
		$display("%0d register writes over %0d settings, %0d mismatches", cfg_writes,
		         PHASES + 1, faults);
		if (faults == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
